FILE: hw/rtl/bcpu_pkg.sv
`timescale 1ns / 1ps

package bcpu_pkg;

  localparam logic [7:0] OP_NOOP    = 8'h00;
  localparam logic [7:0] OP_LDA_LIT = 8'h01;
  localparam logic [7:0] OP_LDA_PTR = 8'h02;
  localparam logic [7:0] OP_LDB_LIT = 8'h11;
  localparam logic [7:0] OP_LDB_PTR = 8'h12;
  localparam logic [7:0] OP_JMP_LIT = 8'hB0;
  localparam logic [7:0] OP_JMP_PTR = 8'hB1;
  localparam logic [7:0] OP_JMP_REG = 8'hB2;
  localparam logic [7:0] OP_HALT    = 8'hF0;

  localparam logic [15:0] PC_RESET = 16'hFFF0;

  localparam logic MODE_LOAD = 1'b0;

endpackage

FILE: hw/rtl/bcpu_mem.sv
`timescale 1ns / 1ps

module bcpu_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);

  localparam int Depth = 1 << ADDR_BITS;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/byte_cpu_instruction_step_unit.sv
`timescale 1ns / 1ps

// Tiny 8-bit CPU step unit. Each request either writes one byte of the shared
// memory (in_mode low) or executes one instruction, and yields one result with
// the halt flag, the unknown-opcode flag, PC, A and B. All bytes come from one
// single-port memory with a registered read, so an instruction runs as a series
// of accesses: NOOP, HALT, JMP reg and unknown opcodes read the opcode, LDA/LDB
// literal also the literal, JMP literal two offset bytes, the pointer forms two
// pointer bytes and the byte they address. A result waits in S_DONE while the
// output register is stalled. One request is worked on at a time. After reset
// the memory's 2^ADDR_BITS bytes are cleared one byte a cycle with in_stall high.
module byte_cpu_instruction_step_unit #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_halted,
  output logic        out_unknown_opcode,
  output logic [15:0] out_program_counter,
  output logic [7:0]  out_accum_a,
  output logic [7:0]  out_accum_b
);

  import bcpu_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OP,
    S_LIT,
    S_HI,
    S_LO,
    S_PTR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  a_r, a_nxt;
  logic [7:0]  b_r, b_nxt;
  logic        halt_r, halt_nxt;
  logic        unk_r, unk_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [7:0]  hi_r, hi_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_halted_r;
  logic        out_unk_r;
  logic [15:0] out_pc_r;
  logic [7:0]  out_a_r;
  logic [7:0]  out_b_r;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;
  logic [15:0]          word;
  logic                 fin;
  logic                 out_free;
  logic                 out_load;

  bcpu_mem #(
    .ADDR_BITS(ADDR_BITS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign word     = {hi_r, mem_rdata};

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pc_nxt      = pc_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    halt_nxt    = halt_r;
    unk_nxt     = unk_r;
    op_nxt      = op_r;
    hi_nxt      = hi_r;
    mem_we      = 1'b0;
    mem_addr    = pc_r[ADDR_BITS-1:0];
    mem_wdata   = in_load_byte;
    fin         = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = 8'h00;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {ADDR_BITS{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        unk_nxt = 1'b0;
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            mem_we   = 1'b1;
            mem_addr = in_load_address[ADDR_BITS-1:0];
            fin      = 1'b1;
          end else if (halt_r) begin
            fin = 1'b1;
          end else begin
            // opcode read goes out at the current pc
            pc_nxt    = pc_r + 16'd1;
            state_nxt = S_OP;
          end
        end
      end
      S_OP: begin
        op_nxt = mem_rdata;
        case (mem_rdata)
          OP_NOOP: begin
            fin = 1'b1;
          end
          OP_HALT: begin
            halt_nxt = 1'b1;
            fin      = 1'b1;
          end
          OP_JMP_REG: begin
            pc_nxt = {a_r, b_r};
            fin    = 1'b1;
          end
          OP_LDA_LIT, OP_LDB_LIT: begin
            pc_nxt    = pc_r + 16'd1;
            state_nxt = S_LIT;
          end
          OP_LDA_PTR, OP_LDB_PTR, OP_JMP_LIT, OP_JMP_PTR: begin
            pc_nxt    = pc_r + 16'd1;
            state_nxt = S_HI;
          end
          default: begin
            unk_nxt = 1'b1;
            fin     = 1'b1;
          end
        endcase
      end
      S_LIT: begin
        if (op_r == OP_LDA_LIT) begin
          a_nxt = mem_rdata;
        end else begin
          b_nxt = mem_rdata;
        end
        fin = 1'b1;
      end
      S_HI: begin
        hi_nxt    = mem_rdata;
        pc_nxt    = pc_r + 16'd1;
        state_nxt = S_LO;
      end
      S_LO: begin
        if (op_r == OP_JMP_LIT) begin
          pc_nxt = pc_r + word;
          fin    = 1'b1;
        end else begin
          // pointer read at the operand word
          mem_addr  = word[ADDR_BITS-1:0];
          state_nxt = S_PTR;
        end
      end
      S_PTR: begin
        case (op_r)
          OP_LDA_PTR: a_nxt = mem_rdata;
          OP_LDB_PTR: b_nxt = mem_rdata;
          default:    pc_nxt = {8'h00, mem_rdata};
        endcase
        fin = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result waits in S_DONE while the output register is still held
    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_DONE;
    end
  end

  assign out_load      = (fin || state_r == S_DONE) && out_free;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= PC_RESET;
      a_r         <= 8'h00;
      b_r         <= 8'h00;
      halt_r      <= 1'b0;
      unk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pc_r        <= pc_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      halt_r      <= halt_nxt;
      unk_r       <= unk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;
    hi_r <= hi_nxt;
    if (out_load) begin
      out_halted_r <= halt_nxt;
      out_unk_r    <= unk_nxt;
      out_pc_r     <= pc_nxt;
      out_a_r      <= a_nxt;
      out_b_r      <= b_nxt;
    end
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_halted          = out_halted_r;
  assign out_unknown_opcode  = out_unk_r;
  assign out_program_counter = out_pc_r;
  assign out_accum_a         = out_a_r;
  assign out_accum_b         = out_b_r;

endmodule

FILE: hw/rtl/bcpu_check.sv
`timescale 1ns / 1ps

module bcpu_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_halted,
  input logic        out_unknown_opcode,
  input logic [15:0] out_program_counter,
  input logic [7:0]  out_accum_a,
  input logic [7:0]  out_accum_b
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
  else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_program_counter) && $stable(out_accum_a)
      && $stable(out_accum_b) && $stable(out_halted) && $stable(out_unknown_opcode))
  else $error("stalled result changed");

  // a request taken behind a stalled result blocks the next one
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && out_valid && out_stall |=> in_stall)
  else $error("request taken with no room for its result");

  // once halted, every later result stays halted
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_halted |=> !out_valid || out_halted)
  else $error("halt flag cleared");

  // a halted cpu never decodes, so never reports an unknown opcode
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unknown_opcode |-> !out_halted)
  else $error("unknown opcode reported while halted");

endmodule

bind byte_cpu_instruction_step_unit bcpu_check u_bcpu_check (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_halted         (out_halted),
  .out_unknown_opcode (out_unknown_opcode),
  .out_program_counter(out_program_counter),
  .out_accum_a        (out_accum_a),
  .out_accum_b        (out_accum_b)
);
